### sv/ctcpq_pkg.sv
// ---------------------------------------------------------------------------
// ctcpq_pkg: shared types and constants of the CTCP quoting codec
// Byte codes, status codes, item and result records, and the result list
// passed from the engine to the output drain.
// ---------------------------------------------------------------------------
`default_nettype none

package ctcpq_pkg;

    // Byte codes of the quoting scheme.
    localparam logic [7:0] MARK_BYTE = 8'h01;
    localparam logic [7:0] ESC_BYTE  = 8'h10;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_N     = 8'h6E;
    localparam logic [7:0] CHR_R     = 8'h72;

    // Largest number of results that one input transaction can cause.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic {
        FUNC_DECODE = 1'b0,
        FUNC_ENCODE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_NO_END   = 2'd2
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_done;
        logic [1:0] status;
    } t_result;

    // Results caused by one input transaction, entry 0 first.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] ent;
        logic    [CNT_W-1:0]       count;
    } t_burst;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic escape_pending;
        logic decode_stopped;
        logic start_missing;
    } t_dec_state;

    function automatic t_result mk_result(logic [7:0] b, logic valid, logic done,
                                          t_status st);
        t_result r;
        r.out_byte     = b;
        r.byte_valid   = valid;
        r.run_last     = 1'b0;
        r.message_done = done;
        r.status       = st;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ctcpq_if.sv
// ---------------------------------------------------------------------------
// ctcpq_if: valid/ready channels of the CTCP quoting codec
// One channel for message bytes going in, one for produced results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ctcpq_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, func, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, func, data_byte, first_byte, last_byte, output ready);
endinterface

interface ctcpq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;
    logic [1:0] status;

    modport source (output valid, out_byte, byte_valid, run_last, message_done, status,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, run_last, message_done, status,
                    output ready);
endinterface

`default_nettype wire

### sv/ctcpq_engine.sv
// ---------------------------------------------------------------------------
// ctcpq_engine: per-byte encode/decode logic and decoder state
// Turns one accepted byte into its list of results and updates the decoder
// state registers on each accepted transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcpq_engine (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  ctcpq_pkg::t_item        i_item,
    output ctcpq_pkg::t_burst       o_burst,
    output ctcpq_pkg::t_dec_state   o_state
);
    import ctcpq_pkg::*;

    t_dec_state r_state;
    t_dec_state n_state;

    // Build the result list for the incoming byte.
    always_comb begin
        t_dec_state          st;
        t_burst              b;
        logic [CNT_W-1:0]    k;
        logic [CNT_W-1:0]    k_last;
        logic                esc;
        logic [7:0]          e;
        logic                prod;
        logic [7:0]          v;
        t_status             code;

        st     = r_state;
        b      = '0;
        k      = '0;
        esc    = 1'b1;
        e      = '0;
        prod   = 1'b0;
        v      = '0;
        code   = ST_OK;
        k_last = '0;

        if (t_func'(i_item.func) == FUNC_ENCODE) begin
            // Encode: opening marker, byte or escape pair, closing marker.
            if (i_item.first_byte) begin
                b.ent[k[1:0]] = mk_result(MARK_BYTE, 1'b1, 1'b0, ST_OK);
                k = k + 1'b1;
            end
            case (i_item.data_byte)
                NUL_BYTE: e = CHR_ZERO;
                LF_BYTE:  e = CHR_N;
                CR_BYTE:  e = CHR_R;
                ESC_BYTE: e = ESC_BYTE;
                default:  esc = 1'b0;
            endcase
            if (esc) begin
                b.ent[k[1:0]] = mk_result(ESC_BYTE, 1'b1, 1'b0, ST_OK);
                k = k + 1'b1;
                b.ent[k[1:0]] = mk_result(e, 1'b1, 1'b0, ST_OK);
                k = k + 1'b1;
            end else begin
                b.ent[k[1:0]] = mk_result(i_item.data_byte, 1'b1, 1'b0, ST_OK);
                k = k + 1'b1;
            end
            if (i_item.last_byte) begin
                b.ent[k[1:0]] = mk_result(MARK_BYTE, 1'b1, 1'b1, ST_OK);
                k = k + 1'b1;
            end
        end else begin
            // Decode: a first byte restarts the state and checks the marker.
            if (i_item.first_byte) begin
                st.escape_pending = 1'b0;
                st.decode_stopped = 1'b0;
                st.start_missing  = (i_item.data_byte != MARK_BYTE);
            end
            // A marker on the first or last byte is framing, not content.
            if (!(i_item.data_byte == MARK_BYTE && (i_item.first_byte || i_item.last_byte))
                && !st.decode_stopped) begin
                if (st.escape_pending) begin
                    st.escape_pending = 1'b0;
                    prod = 1'b1;
                    case (i_item.data_byte)
                        CHR_ZERO: v = NUL_BYTE;
                        CHR_N:    v = LF_BYTE;
                        CHR_R:    v = CR_BYTE;
                        ESC_BYTE: v = ESC_BYTE;
                        default:  prod = 1'b0;
                    endcase
                end else if (i_item.data_byte <= MARK_BYTE) begin
                    st.decode_stopped = 1'b1;
                end else if (i_item.data_byte == ESC_BYTE) begin
                    st.escape_pending = 1'b1;
                end else begin
                    prod = 1'b1;
                    v    = i_item.data_byte;
                end
            end
            if (prod) begin
                b.ent[k[1:0]] = mk_result(v, 1'b1, 1'b0, ST_OK);
                k = k + 1'b1;
            end
            // Last byte: one status result, then the state is cleared.
            if (i_item.last_byte) begin
                if (st.start_missing) begin
                    code = ST_NO_START;
                end else if (i_item.data_byte != MARK_BYTE) begin
                    code = ST_NO_END;
                end
                b.ent[k[1:0]] = mk_result(NUL_BYTE, 1'b0, 1'b1, code);
                k = k + 1'b1;
                st = '0;
            end
        end

        // Flag the final result of this transaction.
        if (k != '0) begin
            k_last = k - 1'b1;
            b.ent[k_last[1:0]].run_last = 1'b1;
        end
        b.count = k;

        o_burst = b;
        n_state = st;
    end

    // Decoder state register; encode transactions leave it unchanged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

### sv/ctcpq_drain.sv
// ---------------------------------------------------------------------------
// ctcpq_drain: result buffer and output register
// Holds the results of one transaction and moves them one per cycle, while the
// output is read, into the output register, which frees the buffer while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcpq_drain (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_load,
    input  ctcpq_pkg::t_burst            i_burst,
    output logic                         o_can_load,
    output logic [ctcpq_pkg::CNT_W-1:0]  o_count,
    ctcpq_out_if.source                  o_result
);
    import ctcpq_pkg::*;

    t_result [MAX_RESULTS-1:0] r_ent;
    logic    [CNT_W-1:0]       r_cnt;
    t_result                   r_out;
    logic                      r_out_valid;
    logic                      out_free;
    logic                      pop;

    // The output register takes a new result when empty or being read.
    assign out_free   = !r_out_valid || o_result.ready;
    assign pop        = (r_cnt != '0) && out_free;
    assign o_can_load = (r_cnt == '0) || (r_cnt == CNT_W'(1) && pop);
    assign o_count    = r_cnt;

    // Buffer: load a whole list, or shift one entry out toward the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_burst.ent;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_ent[0];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_byte     = r_out.out_byte;
    assign o_result.byte_valid   = r_out.byte_valid;
    assign o_result.run_last     = r_out.run_last;
    assign o_result.message_done = r_out.message_done;
    assign o_result.status       = r_out.status;

endmodule

`default_nettype wire

### sv/ctcp_quote_codec.sv
// One input transaction is one message byte; func selects encoding (0x01 framing
// and 0x10 escapes) or decoding (marker check, escape removal, end-of-message
// status). An input transaction that causes at most one result is taken every
// cycle while the output is read; one that causes more results (up to four when
// encoding a first-and-last escaped byte) holds the input until the result
// buffer has drained into the single output register, one result per cycle
// while the output is read. The first result of a transaction goes through the
// result buffer and then the output register, and the rest follow in order.
// Decode items that cause no result do not hold the input.
// ---------------------------------------------------------------------------
// ctcp_quote_codec: CTCP low-level quoting encoder and decoder
// Top level: byte engine with decoder state, result buffer and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcp_quote_codec (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ctcpq_in_if.sink     i_item,
    ctcpq_out_if.source  o_result
);
    import ctcpq_pkg::*;

    t_item              item;
    t_burst             burst;
    t_dec_state         dec_state;
    logic               accept;
    logic               can_load;
    logic [CNT_W-1:0]   buf_count;

    assign item.func       = i_item.func;
    assign item.data_byte  = i_item.data_byte;
    assign item.first_byte = i_item.first_byte;
    assign item.last_byte  = i_item.last_byte;

    assign i_item.ready = can_load;
    assign accept       = i_item.valid && can_load;

    // Encode/decode of the accepted byte.
    ctcpq_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_burst  (burst),
        .o_state  (dec_state)
    );

    // Result buffer and output register.
    ctcpq_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_count    (buf_count),
        .o_result   (o_result)
    );

    // The buffer never holds more than one transaction's results.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_count <= CNT_W'(MAX_RESULTS))
        else $error("result buffer count out of range");

    // A decoded message end clears all decoder state.
    a_dec_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_func'(i_item.func) == FUNC_DECODE && i_item.last_byte)
        |=> (dec_state == '0))
        else $error("decoder state not cleared at message end");

    // A status-only result closes the message and ends its transaction.
    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.byte_valid)
        |-> (o_result.message_done && o_result.run_last))
        else $error("status result without message end");

    // A nonzero status only travels on a status-only result.
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_OK) |-> !o_result.byte_valid)
        else $error("status set on a data byte");

endmodule

`default_nettype wire

### dv/ctcp_quote_codec_tb.sv
// ---------------------------------------------------------------------------
// ctcp_quote_codec_tb: self-checking testbench of the CTCP quoting codec
// A short stimulus table covers the framing, escape and status cases. Random
// encode and decode messages follow. Each result transaction is checked
// against a cycle-free predictor of the codec, or against listed results for
// typed rows, with random idling on both channels.
// ---------------------------------------------------------------------------

module ctcp_quote_codec_tb;

    import ctcpq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 385;
    localparam int TAIL_CYCLES  = 8;

    // One line of stimulus; typed rows carry their expected results.
    typedef struct packed {
        t_item          it;
        logic           drain;
        logic           typed;
        logic [2:0]     n_exp;
        t_result [3:0]  exp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctcpq_in_if  in_ch ();
    ctcpq_out_if out_ch ();

    ctcp_quote_codec i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    t_stim_row  stim_q[$];
    t_result    codec_results_q[$];
    t_dec_state dec_st;
    t_stim_row  cur_row;

    int cyc = 0;
    int errors = 0;
    int stim_idx = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int enc_closes = 0;
    int dec_closes[3] = '{0, 0, 0};

    // Free-running clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result rs(logic [7:0] b, logic v, logic rl, logic done,
                                   t_status st);
        t_result r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.run_last     = rl;
        r.message_done = done;
        r.status       = st;
        return r;
    endfunction

    function automatic void add_row(logic f, logic [7:0] b, logic fb, logic lb);
        t_stim_row row;
        row = '0;
        row.it.func       = f;
        row.it.data_byte  = b;
        row.it.first_byte = fb;
        row.it.last_byte  = lb;
        stim_q.push_back(row);
    endfunction

    function automatic void add_typed(logic f, logic [7:0] b, logic fb, logic lb,
                                      int n, t_result r0, t_result r1 = '0,
                                      t_result r2 = '0, t_result r3 = '0);
        t_stim_row row;
        row = '0;
        row.it.func       = f;
        row.it.data_byte  = b;
        row.it.first_byte = fb;
        row.it.last_byte  = lb;
        row.typed         = 1'b1;
        row.n_exp         = n[2:0];
        row.exp[0]        = r0;
        row.exp[1]        = r1;
        row.exp[2]        = r2;
        row.exp[3]        = r3;
        stim_q.push_back(row);
    endfunction

    // Encode content biased toward the bytes that need escaping.
    function automatic logic [7:0] enc_byte();
        if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 4))
                0:       return NUL_BYTE;
                1:       return LF_BYTE;
                2:       return CR_BYTE;
                3:       return ESC_BYTE;
                default: return MARK_BYTE;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One body element of a decode message: plain byte, escape pair, stop byte
    // or an encode transaction slipped into the middle of the message.
    function automatic void add_decode_body();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            add_row(FUNC_DECODE, 8'($urandom_range(0, 1)), 1'b0, 1'b0);
        end else if (r < 18) begin
            add_row(FUNC_DECODE, ESC_BYTE, 1'b0, 1'b0);
            case ($urandom_range(0, 4))
                0:       add_row(FUNC_DECODE, CHR_ZERO, 1'b0, 1'b0);
                1:       add_row(FUNC_DECODE, CHR_N, 1'b0, 1'b0);
                2:       add_row(FUNC_DECODE, CHR_R, 1'b0, 1'b0);
                3:       add_row(FUNC_DECODE, ESC_BYTE, 1'b0, 1'b0);
                default: add_row(FUNC_DECODE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            endcase
        end else if (r < 22) begin
            add_row(FUNC_ENCODE, enc_byte(), 1'b0, 1'b0);
        end else begin
            add_row(FUNC_DECODE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endfunction

    // Random part: mostly well-framed messages, some noise transactions.
    function automatic void add_random_msgs(int target);
        int pick;
        int n_body;
        logic [7:0] b;
        while (stim_q.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                add_row(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 45) begin
                n_body = $urandom_range(1, 6);
                for (int k = 0; k < n_body; k++) begin
                    add_row(FUNC_ENCODE, enc_byte(), k == 0, k == n_body - 1);
                end
            end else if (pick < 50) begin
                b = ($urandom_range(0, 1) == 0) ? MARK_BYTE : 8'($urandom_range(0, 255));
                add_row(FUNC_DECODE, b, 1'b1, 1'b1);
            end else begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : MARK_BYTE;
                add_row(FUNC_DECODE, b, 1'b1, 1'b0);
                n_body = $urandom_range(0, 7);
                for (int k = 0; k < n_body; k++) begin
                    add_decode_body();
                end
                b = ($urandom_range(0, 99) < 85) ? MARK_BYTE : 8'($urandom_range(0, 255));
                add_row(FUNC_DECODE, b, 1'b0, 1'b1);
            end
        end
    endfunction

    // Predicts the results of one accepted byte and updates the decoder state.
    function automatic void quote_codec_step(t_item it, bit keep);
        t_result    burst[$];
        logic [7:0] esc_code;
        logic [7:0] v;
        logic       esc;
        logic       produced;
        t_status    st;
        if (it.func == FUNC_ENCODE) begin
            if (it.first_byte) burst.push_back(rs(MARK_BYTE, 1'b1, 1'b0, 1'b0, ST_OK));
            esc      = 1'b1;
            esc_code = '0;
            case (it.data_byte)
                NUL_BYTE: esc_code = CHR_ZERO;
                LF_BYTE:  esc_code = CHR_N;
                CR_BYTE:  esc_code = CHR_R;
                ESC_BYTE: esc_code = ESC_BYTE;
                default:  esc = 1'b0;
            endcase
            if (esc) begin
                burst.push_back(rs(ESC_BYTE, 1'b1, 1'b0, 1'b0, ST_OK));
                burst.push_back(rs(esc_code, 1'b1, 1'b0, 1'b0, ST_OK));
            end else begin
                burst.push_back(rs(it.data_byte, 1'b1, 1'b0, 1'b0, ST_OK));
            end
            if (it.last_byte) burst.push_back(rs(MARK_BYTE, 1'b1, 1'b0, 1'b1, ST_OK));
        end else begin
            if (it.first_byte) begin
                dec_st = '0;
                if (it.data_byte != MARK_BYTE) dec_st.start_missing = 1'b1;
            end
            // A marker byte at either end of the message is framing, not content.
            if (!(it.data_byte == MARK_BYTE && (it.first_byte || it.last_byte))) begin
                produced = 1'b0;
                v        = it.data_byte;
                if (dec_st.decode_stopped) begin
                    produced = 1'b0;
                end else if (dec_st.escape_pending) begin
                    dec_st.escape_pending = 1'b0;
                    produced = 1'b1;
                    case (it.data_byte)
                        CHR_ZERO: v = NUL_BYTE;
                        CHR_N:    v = LF_BYTE;
                        CHR_R:    v = CR_BYTE;
                        ESC_BYTE: v = ESC_BYTE;
                        default:  produced = 1'b0;
                    endcase
                end else if (it.data_byte <= MARK_BYTE) begin
                    dec_st.decode_stopped = 1'b1;
                end else if (it.data_byte == ESC_BYTE) begin
                    dec_st.escape_pending = 1'b1;
                end else begin
                    produced = 1'b1;
                end
                if (produced) burst.push_back(rs(v, 1'b1, 1'b0, 1'b0, ST_OK));
            end
            if (it.last_byte) begin
                if (dec_st.start_missing)          st = ST_NO_START;
                else if (it.data_byte != MARK_BYTE) st = ST_NO_END;
                else                               st = ST_OK;
                burst.push_back(rs(8'h00, 1'b0, 1'b0, 1'b1, st));
                dec_st = '0;
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
        if (keep) begin
            foreach (burst[k]) codec_results_q.push_back(burst[k]);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Gap length: mostly none, some short, a few long; none in quiet stretches.
    function automatic int idle_len();
        int r;
        if (((cyc / 256) % 5) == 4) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Checks result transactions, drives input transactions and output ready.
    always @(posedge i_clk) begin : drive_and_check
        t_result want;
        logic    nxt_valid;
        cyc = cyc + 1;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            // Result side.
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (codec_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got byte %02h status %0d",
                             $time, out_ch.out_byte, out_ch.status);
                    errors++;
                end else begin
                    want = codec_results_q.pop_front();
                    check_field("out_byte", want.out_byte, out_ch.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
                    check_field("run_last", 8'(want.run_last), 8'(out_ch.run_last));
                    check_field("message_done", 8'(want.message_done),
                                8'(out_ch.message_done));
                    check_field("status", 8'(want.status), 8'(out_ch.status));
                end
                if (out_ch.message_done === 1'b1) begin
                    if (out_ch.byte_valid === 1'b1)  enc_closes++;
                    else if (out_ch.status < 2'd3)   dec_closes[out_ch.status]++;
                end
            end

            // Input side.
            nxt_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                bytes_sent++;
                quote_codec_step(cur_row.it, !cur_row.typed);
                if (cur_row.typed) begin
                    for (int k = 0; k < cur_row.n_exp; k++) begin
                        codec_results_q.push_back(cur_row.exp[k]);
                    end
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stim_idx < stim_q.size() &&
                             !(stim_q[stim_idx].drain && codec_results_q.size() != 0)) begin
                    cur_row = stim_q[stim_idx];
                    stim_idx++;
                    in_ch.func       <= cur_row.it.func;
                    in_ch.data_byte  <= cur_row.it.data_byte;
                    in_ch.first_byte <= cur_row.it.first_byte;
                    in_ch.last_byte  <= cur_row.it.last_byte;
                    nxt_valid = 1'b1;
                    send_gap  = idle_len();
                end
            end
            in_ch.valid <= nxt_valid;

            // Receiver stalls.
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_stall = idle_len();
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin
        wait (cyc >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cyc);
        $display("ctcp_quote_codec regression: fail");
        $finish;
    end

    // Stimulus table, reset and end of run.
    initial begin
        int n_dir;
        in_ch.valid      = 1'b0;
        in_ch.func       = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        i_rst_n          = 1'b0;
        dec_st           = '0;

        // Single marker byte straight after reset: start and end at once.
        add_typed(FUNC_DECODE, MARK_BYTE, 1, 1, 1, rs(8'h00, 0, 1, 1, ST_OK));
        // Framed message with the 0 and r escapes, an unknown escape, a high byte and
        // an escape cut off by the closing marker.
        add_row(FUNC_DECODE, MARK_BYTE, 1, 0);
        add_row(FUNC_DECODE, ESC_BYTE, 0, 0);
        add_row(FUNC_DECODE, CHR_ZERO, 0, 0);
        add_row(FUNC_DECODE, ESC_BYTE, 0, 0);
        add_row(FUNC_DECODE, CHR_R, 0, 0);
        add_row(FUNC_DECODE, ESC_BYTE, 0, 0);
        add_row(FUNC_DECODE, 8'h78, 0, 0);
        add_row(FUNC_DECODE, 8'hFF, 0, 0);
        add_row(FUNC_DECODE, ESC_BYTE, 0, 0);
        add_typed(FUNC_DECODE, MARK_BYTE, 0, 1, 1, rs(8'h00, 0, 1, 1, ST_OK));
        // Missing start marker.
        add_row(FUNC_DECODE, 8'h80, 1, 0);
        add_typed(FUNC_DECODE, 8'h7F, 0, 1, 2, rs(8'h7F, 1, 0, 0, ST_OK),
                  rs(8'h00, 0, 1, 1, ST_NO_START));
        // Missing end marker after a stop byte.
        add_row(FUNC_DECODE, MARK_BYTE, 1, 0);
        add_row(FUNC_DECODE, NUL_BYTE, 0, 0);
        add_typed(FUNC_DECODE, 8'h41, 0, 1, 1, rs(8'h00, 0, 1, 1, ST_NO_END));
        // Continuation after a message end, without a first mark.
        add_typed(FUNC_DECODE, 8'h42, 0, 1, 2, rs(8'h42, 1, 0, 0, ST_OK),
                  rs(8'h00, 0, 1, 1, ST_NO_END));
        // Encode: largest burst, then a short framed message.
        add_typed(FUNC_ENCODE, NUL_BYTE, 1, 1, 4, rs(MARK_BYTE, 1, 0, 0, ST_OK),
                  rs(ESC_BYTE, 1, 0, 0, ST_OK), rs(CHR_ZERO, 1, 0, 0, ST_OK),
                  rs(MARK_BYTE, 1, 1, 1, ST_OK));
        add_row(FUNC_ENCODE, LF_BYTE, 1, 0);
        add_row(FUNC_ENCODE, ESC_BYTE, 0, 0);
        add_typed(FUNC_ENCODE, 8'hFF, 0, 1, 2, rs(8'hFF, 1, 0, 0, ST_OK),
                  rs(MARK_BYTE, 1, 1, 1, ST_OK));
        // Mode changes inside a decode message.
        add_row(FUNC_DECODE, MARK_BYTE, 1, 0);
        add_row(FUNC_ENCODE, MARK_BYTE, 0, 0);
        add_row(FUNC_DECODE, ESC_BYTE, 0, 0);
        add_row(FUNC_ENCODE, CR_BYTE, 0, 0);
        add_row(FUNC_DECODE, CHR_R, 0, 1);

        n_dir = stim_q.size();
        add_random_msgs(n_dir + RANDOM_ITEMS);
        // Sender waits for all results before the random part and once within it.
        stim_q[n_dir].drain = 1'b1;
        stim_q[n_dir + $urandom_range(100, 300)].drain = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (stim_idx < stim_q.size() || in_ch.valid || codec_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (codec_results_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     codec_results_q.size());
            errors++;
        end

        $display("Covered %0d message bytes and %0d result transactions in %0d cycles.",
                 bytes_sent, results_seen, cyc);
        $display("Closed %0d encoded messages; decode status ok/no-start/no-end %0d/%0d/%0d.",
                 enc_closes, dec_closes[0], dec_closes[1], dec_closes[2]);
        if (errors == 0) begin
            $display("ctcp_quote_codec regression: pass");
        end else begin
            $display("ctcp_quote_codec regression: fail");
        end
        $finish;
    end

endmodule
